FILE: design/tdsc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tdsc_pkg
// Shared constants for the text drop-shadow compositor: register indexes,
// field widths, the fixed-point constants of the alpha-over blend and the controller state type.
// ============================================================================
package tdsc_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam int PIX_W  = 32;
    localparam int CH_W   = 8;
    localparam int DIM_W  = 13;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 13;

    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_TEXT_RED     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TEXT_GREEN   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TEXT_BLUE    = 3'd4;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

    // floor(x / 255) = (x * 0x8081) >> 23 for every 16-bit x.
    localparam logic [31:0] RECIP_255     = 32'h0000_8081;
    localparam int          RECIP_SHIFT   = 23;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_RUN   = 5'b00010,
        S_FA    = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

FILE: design/text_drop_shadow_composite_core.sv
`timescale 1ns / 1ps
// ============================================================================
// text_drop_shadow_composite_core
// Streams a text raster with a one-pixel black drop shadow, alpha-over
// blending the text color where the shadow shows through partial coverage.
// ============================================================================
// The input channel carries one transaction per output position in raster
// order, with zero outside the source image and frame_start on the first one.
// The output channel returns one transaction per input transaction, in order.
// The previous row's alphas live in a single-port line memory that is read
// and rewritten at the current column on every accepted transaction.
// A pixel that passes through, or that lies on the shadow-only edge, goes
// straight to the output register and the block stays in S_RUN, ready once
// that register is free. A blended pixel passes S_RUN (accept), S_FA (form
// the final alpha), S_DIV (the bit-serial restoring dividers, one quotient
// bit per cycle) and S_DONE (hand the result to the output register).
// After reset the line memory is cleared, one entry per cycle, over all
// MAX_WIDTH+1 entries; no input transaction is accepted during that pass,
// while configuration writes are taken at any time.
// The output register holds its transaction while the receiver stalls; a new
// input transaction is accepted only when that register is empty or being
// emptied in the same cycle.
// ============================================================================
module text_drop_shadow_composite_core #(
    parameter int MAX_WIDTH = tdsc_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_wr_en,
    input  logic [tdsc_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [tdsc_pkg::CFG_DW-1:0]   i_cfg_wdata,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tdsc_pkg::PIX_W-1:0]    i_src_pixel,
    input  logic                          i_frame_start,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tdsc_pkg::PIX_W-1:0]    o_out_pixel,
    output logic                          o_end_of_row,
    output logic                          o_end_of_image
);

    localparam int DEPTH = MAX_WIDTH + 1;
    localparam int CW    = $clog2(DEPTH);
    localparam int EW    = (CW > tdsc_pkg::DIM_W) ? CW : tdsc_pkg::DIM_W;
    localparam int CHW   = tdsc_pkg::CH_W;
    localparam int DW    = tdsc_pkg::DIM_W;

    // Configuration registers.
    logic [DW-1:0]  r_width, r_height;
    logic [CHW-1:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DW'(1);
            r_height <= DW'(1);
            r_red    <= '0;
            r_green  <= '0;
            r_blue   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tdsc_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[DW-1:0];
                tdsc_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[DW-1:0];
                tdsc_pkg::REG_TEXT_RED:     r_red    <= i_cfg_wdata[CHW-1:0];
                tdsc_pkg::REG_TEXT_GREEN:   r_green  <= i_cfg_wdata[CHW-1:0];
                tdsc_pkg::REG_TEXT_BLUE:    r_blue   <= i_cfg_wdata[CHW-1:0];
                default: ;
            endcase
        end
    end

    // Control and datapath registers.
    tdsc_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_clr_addr;
    logic [CW-1:0]    r_col;
    logic [DW-1:0]    r_row;
    logic [CHW-1:0]   r_hold;
    logic             r_out_valid;
    logic [31:0]      r_out_pixel;
    logic             r_out_eor, r_out_eoi;
    logic             r_pend_eor, r_pend_eoi;
    logic [CHW-1:0]   r_sa;
    logic [15:0]      r_prod;
    logic [CHW-1:0]   r_fa;
    logic [2:0]       r_step;
    logic [15:0]      r_num [3];
    logic [CHW-1:0]   r_rem [3];

    logic [CHW-1:0]   line_mem [DEPTH];

    // Current position and edge decisions.
    logic             in_acc, out_take, out_free;
    logic [CW-1:0]    c_cur;
    logic [DW-1:0]    row_cur;
    logic [EW-1:0]    w_ext, w_eff, c_ext;
    logic [DW-1:0]    h_eff;
    logic             last_col, last_row;
    logic [CHW-1:0]   sa, ha;
    logic             is_blend;
    logic [31:0]      pass_pixel;

    assign out_take = r_out_valid & i_out_ready;
    assign out_free = !r_out_valid | i_out_ready;
    assign o_in_ready = (r_state == tdsc_pkg::S_RUN) & out_free;
    assign in_acc = i_in_valid & o_in_ready;

    always_comb begin
        c_cur   = i_frame_start ? '0 : r_col;
        row_cur = i_frame_start ? '0 : r_row;
        w_ext   = EW'(r_width);
        if (w_ext == '0) begin
            w_eff = EW'(1);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_eff    = (r_height == '0) ? DW'(1) : r_height;
        c_ext    = EW'(c_cur);
        last_col = c_ext >= w_eff;
        last_row = row_cur >= h_eff;
        sa       = i_src_pixel[31:24];
        ha       = (c_cur != '0 && row_cur != '0) ? r_hold : '0;
        is_blend = 1'b0;
        if (c_cur == '0 || row_cur == '0) begin
            pass_pixel = i_src_pixel;
        end else if (last_col || last_row) begin
            pass_pixel = {ha, 24'h0};
        end else if (sa == tdsc_pkg::ALPHA_OPAQUE || ha == '0) begin
            pass_pixel = i_src_pixel;
        end else begin
            pass_pixel = i_src_pixel;
            is_blend   = 1'b1;
        end
    end

    // Line memory: clearing pass after reset, then read-first update.
    logic          mem_we;
    logic [CW-1:0] mem_addr;
    logic [CHW-1:0] mem_wdata;

    always_comb begin
        if (r_state == tdsc_pkg::S_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = in_acc;
            mem_addr  = c_cur;
            mem_wdata = sa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            line_mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (in_acc) begin
            r_hold <= line_mem[c_cur];
        end
    end

    // Blend arithmetic.
    logic [31:0] q_prod;
    logic [8:0]  fa_sum;
    logic [CHW-1:0] fa_val;
    logic [CHW-1:0] color [3];
    logic [8:0]  div_t [3];
    logic        div_ge [3];

    always_comb begin
        q_prod = 32'(r_prod) * tdsc_pkg::RECIP_255;
        fa_sum = 9'(r_sa) + 9'(q_prod[tdsc_pkg::RECIP_SHIFT +: CHW]);
        fa_val = fa_sum[8] ? tdsc_pkg::ALPHA_OPAQUE : fa_sum[CHW-1:0];
        color[0] = r_red;
        color[1] = r_green;
        color[2] = r_blue;
        for (int k = 0; k < 3; k++) begin
            div_t[k]  = {r_rem[k], r_num[k][15]};
            div_ge[k] = div_t[k] >= {1'b0, r_fa};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tdsc_pkg::S_CLEAR: if (r_clr_addr == CW'(MAX_WIDTH)) n_state = tdsc_pkg::S_RUN;
            tdsc_pkg::S_RUN:   if (in_acc && is_blend) n_state = tdsc_pkg::S_FA;
            tdsc_pkg::S_FA:    n_state = tdsc_pkg::S_DIV;
            tdsc_pkg::S_DIV:   if (r_step == 3'd7) n_state = tdsc_pkg::S_DONE;
            tdsc_pkg::S_DONE:  if (out_free) n_state = tdsc_pkg::S_RUN;
            default:           n_state = tdsc_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdsc_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == tdsc_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + CW'(1);
            end
            if (in_acc) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : row_cur + DW'(1);
                end else begin
                    r_col <= c_cur + CW'(1);
                    r_row <= row_cur;
                end
            end
            if (r_state == tdsc_pkg::S_DIV) begin
                r_step <= r_step + 3'd1;
            end else begin
                r_step <= '0;
            end
            if ((in_acc && !is_blend) || (r_state == tdsc_pkg::S_DONE && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !is_blend) begin
            r_out_pixel <= pass_pixel;
            r_out_eor   <= last_col;
            r_out_eoi   <= last_col & last_row;
        end else if (r_state == tdsc_pkg::S_DONE && out_free) begin
            r_out_pixel <= {r_fa, r_num[2][CHW-1:0], r_num[1][CHW-1:0], r_num[0][CHW-1:0]};
            r_out_eor   <= r_pend_eor;
            r_out_eoi   <= r_pend_eoi;
        end
        if (in_acc) begin
            r_sa       <= sa;
            r_prod     <= 16'(ha) * 16'(tdsc_pkg::ALPHA_OPAQUE - sa);
            r_pend_eor <= last_col;
            r_pend_eoi <= last_col & last_row;
        end
        if (r_state == tdsc_pkg::S_FA) begin
            r_fa <= fa_val;
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= {8'h0, color[k]} * {8'h0, r_sa};
                r_rem[k] <= '0;
            end
        end else if (r_state == tdsc_pkg::S_DIV) begin
            for (int k = 0; k < 3; k++) begin
                if (r_step == 3'd0) begin
                    // The high byte is already below the divisor; start on bit 7.
                    if ({r_num[k][15:8], r_num[k][7]} >= {1'b0, r_fa}) begin
                        r_rem[k] <= 8'({r_num[k][15:8], r_num[k][7]} - {1'b0, r_fa});
                        r_num[k] <= {r_num[k][6:0], 8'h0, 1'b1};
                    end else begin
                        r_rem[k] <= {r_num[k][14:8], r_num[k][7]};
                        r_num[k] <= {r_num[k][6:0], 8'h0, 1'b0};
                    end
                end else begin
                    if (div_ge[k]) begin
                        r_rem[k] <= 8'(div_t[k] - {1'b0, r_fa});
                    end else begin
                        r_rem[k] <= div_t[k][CHW-1:0];
                    end
                    r_num[k] <= {r_num[k][14:0], div_ge[k]};
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_pixel    = r_out_pixel;
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_image = r_out_eoi;

endmodule
